FILE: src/qrs_pkg.sv
// shared types and constants of the quadratic root solver
`default_nettype none

package qrs_pkg;

  localparam int CoefW  = 16;              // q8.8 coefficient width
  localparam int PolyW  = 48;              // q24.24 polynomial value
  localparam int RootW  = 32;              // q16.16 root, also sqrt result width
  localparam int RadW   = 2 * RootW;       // sqrt radicand width
  localparam int DiscW  = 35;              // discriminant, |d| < 2^33
  localparam int NumW   = 33;              // numerator magnitude width
  localparam int NumSW  = NumW + 2;        // signed numerator / quotient width
  localparam int DenW   = CoefW;           // divisor magnitude width

  localparam logic [RootW-1:0] RootMax = {1'b0, {(RootW-1){1'b1}}};
  localparam logic [RootW-1:0] RootMin = {1'b1, {(RootW-1){1'b0}}};

  // data carried alongside the square root
  typedef struct packed {
    logic signed [PolyW-1:0] poly;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
    logic                    a_zero;
    logic                    d_pos;
    logic                    d_zero;
  } sqrt_side_t;

  // data carried alongside the divider
  typedef struct packed {
    logic signed [PolyW-1:0] poly;
    logic                    neg_p;
    logic                    neg_m;
    logic                    found_p;
    logic                    found_m;
  } div_side_t;

endpackage

`default_nettype wire

FILE: src/qrs_in_if.sv
// request channel of the quadratic root solver
`default_nettype none

interface qrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coef_a;
  logic signed [15:0] coef_b;
  logic signed [15:0] coef_c;
  logic signed [15:0] point_x;

  modport source (output valid, coef_a, coef_b, coef_c, point_x, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, point_x, output ready);
endinterface

`default_nettype wire

FILE: src/qrs_out_if.sv
// result channel of the quadratic root solver
`default_nettype none

interface qrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] poly_value;
  logic signed [31:0] root_plus;
  logic signed [31:0] root_minus;
  logic               first_found;
  logic               second_found;
  logic               root_saturated;

  modport source (output valid, poly_value, root_plus, root_minus, first_found,
                  second_found, root_saturated, input ready);
  modport sink   (input valid, poly_value, root_plus, root_minus, first_found,
                  second_found, root_saturated, output ready);
endinterface

`default_nettype wire

FILE: src/qrs_sqrt.sv
// pipelined floor square root, one result bit per stage
`default_nettype none

module qrs_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [qrs_pkg::RadW-1:0]    rad_i,
  input  qrs_pkg::sqrt_side_t         side_i,
  output logic                        valid_o,
  output logic [qrs_pkg::RootW-1:0]   root_o,
  output qrs_pkg::sqrt_side_t         side_o
);
  import qrs_pkg::*;

  logic             vld_q  [RootW];
  logic [RootW+1:0] rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RadW-1:0]  rad_q  [RootW];
  sqrt_side_t       side_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic             vld_in;
    logic [RootW+1:0] rem_in;
    logic [RootW-1:0] root_in;
    logic [RadW-1:0]  rad_in;
    sqrt_side_t       side_in;
    logic [RootW+1:0] cand;
    logic [RootW+1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cand  = {rem_in[RootW-1:0], rad_in[RadW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign take  = cand >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? cand - trial : cand;
        root_q[k] <= {root_in[RootW-2:0], take};
        rad_q[k]  <= {rad_in[RadW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

`default_nettype wire

FILE: src/qrs_div.sv
// pipelined restoring divider, two numerators over one divisor
`default_nettype none

module qrs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [qrs_pkg::NumW-1:0]   num_p_i,
  input  logic [qrs_pkg::NumW-1:0]   num_m_i,
  input  logic [qrs_pkg::DenW-1:0]   den_i,
  input  qrs_pkg::div_side_t         side_i,
  output logic                       valid_o,
  output logic [qrs_pkg::NumW-1:0]   quot_p_o,
  output logic [qrs_pkg::NumW-1:0]   quot_m_o,
  output qrs_pkg::div_side_t         side_o
);
  import qrs_pkg::*;

  logic            vld_q   [NumW];
  logic [DenW:0]   rem_p_q [NumW];
  logic [DenW:0]   rem_m_q [NumW];
  logic [NumW-1:0] num_p_q [NumW];
  logic [NumW-1:0] num_m_q [NumW];
  logic [NumW-1:0] quo_p_q [NumW];
  logic [NumW-1:0] quo_m_q [NumW];
  logic [DenW-1:0] den_q   [NumW];
  div_side_t       side_q  [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic            vld_in;
    logic [DenW:0]   rem_p_in, rem_m_in;
    logic [NumW-1:0] num_p_in, num_m_in;
    logic [NumW-1:0] quo_p_in, quo_m_in;
    logic [DenW-1:0] den_in;
    div_side_t       side_in;
    logic [DenW:0]   cand_p, cand_m, den_x;
    logic            take_p, take_m;

    if (k == 0) begin : g_first
      assign vld_in   = valid_i;
      assign rem_p_in = '0;
      assign rem_m_in = '0;
      assign num_p_in = num_p_i;
      assign num_m_in = num_m_i;
      assign quo_p_in = '0;
      assign quo_m_in = '0;
      assign den_in   = den_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign vld_in   = vld_q[k-1];
      assign rem_p_in = rem_p_q[k-1];
      assign rem_m_in = rem_m_q[k-1];
      assign num_p_in = num_p_q[k-1];
      assign num_m_in = num_m_q[k-1];
      assign quo_p_in = quo_p_q[k-1];
      assign quo_m_in = quo_m_q[k-1];
      assign den_in   = den_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign den_x  = {1'b0, den_in};
    assign cand_p = {rem_p_in[DenW-1:0], num_p_in[NumW-1]};
    assign cand_m = {rem_m_in[DenW-1:0], num_m_in[NumW-1]};
    assign take_p = cand_p >= den_x;
    assign take_m = cand_m >= den_x;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_p_q[k] <= take_p ? cand_p - den_x : cand_p;
        rem_m_q[k] <= take_m ? cand_m - den_x : cand_m;
        num_p_q[k] <= {num_p_in[NumW-2:0], 1'b0};
        num_m_q[k] <= {num_m_in[NumW-2:0], 1'b0};
        quo_p_q[k] <= {quo_p_in[NumW-2:0], take_p};
        quo_m_q[k] <= {quo_m_in[NumW-2:0], take_m};
        den_q[k]   <= den_in;
        side_q[k]  <= side_in;
      end
    end
  end

  assign valid_o  = vld_q[NumW-1];
  assign quot_p_o = quo_p_q[NumW-1];
  assign quot_m_o = quo_m_q[NumW-1];
  assign side_o   = side_q[NumW-1];

endmodule

`default_nettype wire

FILE: src/quadratic_root_solver.sv
// top level of the quadratic root solver
`default_nettype none

// Evaluates a*x*x + b*x + c exactly (q24.24) and finds the real roots of the
// quadratic (q16.16, truncated toward zero, saturating) for every request.
// The block is a 70-stage pipeline: an input register, two stages of
// multipliers and adders for the polynomial and discriminant, a 32-stage
// square root (one root bit per stage), one stage forming the numerators, a
// 33-stage divider (one quotient bit per stage) and an output register. It
// takes one request per cycle while the pipeline advances. The whole
// pipeline advances together; it holds only while a result waits at the
// output, and then req_i.ready is low.
module quadratic_root_solver (
  input  logic      clk_i,
  input  logic      rst_ni,
  qrs_in_if.sink    req_i,
  qrs_out_if.source rsp_o
);
  import qrs_pkg::*;

  logic adv;

  // output register state
  logic                    out_vld_q;
  logic signed [PolyW-1:0] out_poly_q;
  logic [RootW-1:0]        out_rp_q, out_rm_q;
  logic                    out_f1_q, out_f2_q, out_sat_q;

  // pipeline moves whenever the output is free or being taken
  assign adv         = !out_vld_q || rsp_o.ready;
  assign req_i.ready = adv;

  // stage 1: captured request
  logic                    v1_q;
  logic signed [CoefW-1:0] a1_q, b1_q, c1_q, x1_q;

  // stage 2: first products
  logic                    v2_q;
  logic signed [2*CoefW-1:0] ax2_q, bx2_q, bb2_q, ac2_q;
  logic signed [CoefW-1:0] a2_q, b2_q, c2_q, x2_q;

  // stage 3: a*x*x and discriminant
  logic                    v3_q;
  logic signed [PolyW-1:0] axx3_q;
  logic signed [2*CoefW-1:0] bx3_q;
  logic signed [DiscW-1:0] d3_q;
  logic signed [CoefW-1:0] a3_q, b3_q, c3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q   <= req_i.coef_a;
      b1_q   <= req_i.coef_b;
      c1_q   <= req_i.coef_c;
      x1_q   <= req_i.point_x;
      // all products of the raw q8.8 integers
      ax2_q  <= a1_q * x1_q;
      bx2_q  <= b1_q * x1_q;
      bb2_q  <= b1_q * b1_q;
      ac2_q  <= a1_q * c1_q;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      c2_q   <= c1_q;
      x2_q   <= x1_q;
      axx3_q <= PolyW'(ax2_q) * PolyW'(x2_q);
      d3_q   <= DiscW'(bb2_q) - (DiscW'(ac2_q) <<< 2);
      bx3_q  <= bx2_q;
      a3_q   <= a2_q;
      b3_q   <= b2_q;
      c3_q   <= c2_q;
    end
  end

  // stage 3 combinational: polynomial sum and sqrt radicand d*2^30
  sqrt_side_t       sq_side_in;
  logic [RadW-1:0]  rad;
  logic             d_pos;

  assign d_pos = !d3_q[DiscW-1] && (d3_q != '0);
  assign rad   = d_pos ? (RadW'(d3_q) << 30) : '0;

  always_comb begin
    sq_side_in.poly   = axx3_q + (PolyW'(bx3_q) <<< 8) + (PolyW'(c3_q) <<< 16);
    sq_side_in.a      = a3_q;
    sq_side_in.b      = b3_q;
    sq_side_in.c      = c3_q;
    sq_side_in.a_zero = (a3_q == '0);
    sq_side_in.d_pos  = d_pos;
    sq_side_in.d_zero = (d3_q == '0);
  end

  logic             sq_vld;
  logic [RootW-1:0] sq_root;
  sqrt_side_t       sq_side;

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   (rad),
    .side_i  (sq_side_in),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // numerator forming: quadratic uses (-b*2^15 +/- s) / a, linear -c*2^16 / b
  logic signed [NumSW-1:0] nb, s_ext, np, nm;
  logic signed [CoefW-1:0] den;
  logic                    f1, f2;

  assign nb    = -(NumSW'(sq_side.b) <<< 15);
  assign s_ext = {{(NumSW-RootW){1'b0}}, sq_root};

  always_comb begin
    np  = '0;
    nm  = '0;
    den = sq_side.a;
    f1  = 1'b0;
    f2  = 1'b0;
    if (sq_side.a_zero) begin
      np  = -(NumSW'(sq_side.c) <<< 16);
      den = sq_side.b;
      f1  = (sq_side.b != '0);
    end else if (sq_side.d_pos) begin
      np = nb + s_ext;
      nm = nb - s_ext;
      f1 = 1'b1;
      f2 = 1'b1;
    end else if (sq_side.d_zero) begin
      np = nb;
      f1 = 1'b1;
    end
  end

  logic            v4_q;
  logic [NumW-1:0] mp4_q, mm4_q;
  logic [DenW-1:0] den4_q;
  div_side_t       dv_side4_q;
  logic [NumSW-1:0] abs_p, abs_m;

  assign abs_p = np[NumSW-1] ? -np : np;
  assign abs_m = nm[NumSW-1] ? -nm : nm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mp4_q              <= abs_p[NumW-1:0];
      mm4_q              <= abs_m[NumW-1:0];
      den4_q             <= den[CoefW-1] ? -den : den;
      dv_side4_q.poly    <= sq_side.poly;
      dv_side4_q.neg_p   <= np[NumSW-1] ^ den[CoefW-1];
      dv_side4_q.neg_m   <= nm[NumSW-1] ^ den[CoefW-1];
      dv_side4_q.found_p <= f1;
      dv_side4_q.found_m <= f2;
    end
  end

  logic            dv_vld;
  logic [NumW-1:0] q_p, q_m;
  div_side_t       dv_side;

  qrs_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (v4_q),
    .num_p_i  (mp4_q),
    .num_m_i  (mm4_q),
    .den_i    (den4_q),
    .side_i   (dv_side4_q),
    .valid_o  (dv_vld),
    .quot_p_o (q_p),
    .quot_m_o (q_m),
    .side_o   (dv_side)
  );

  // sign restore and saturation to q16.16
  logic [NumSW-1:0]   qs_p, qs_m;
  logic [NumSW-RootW:0] hi_p, hi_m;
  logic               fit_p, fit_m;
  logic [RootW-1:0]   rp, rm;
  logic               sat;

  assign qs_p  = dv_side.neg_p ? -{2'b00, q_p} : {2'b00, q_p};
  assign qs_m  = dv_side.neg_m ? -{2'b00, q_m} : {2'b00, q_m};
  assign hi_p  = qs_p[NumSW-1:RootW-1];
  assign hi_m  = qs_m[NumSW-1:RootW-1];
  assign fit_p = (&hi_p) || !(|hi_p);
  assign fit_m = (&hi_m) || !(|hi_m);

  always_comb begin
    rp  = '0;
    rm  = '0;
    sat = 1'b0;
    if (dv_side.found_p) begin
      rp  = fit_p ? qs_p[RootW-1:0] : (qs_p[NumSW-1] ? RootMin : RootMax);
      sat = !fit_p;
    end
    if (dv_side.found_m) begin
      rm  = fit_m ? qs_m[RootW-1:0] : (qs_m[NumSW-1] ? RootMin : RootMax);
      sat = sat || !fit_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_poly_q <= dv_side.poly;
      out_rp_q   <= rp;
      out_rm_q   <= rm;
      out_f1_q   <= dv_side.found_p;
      out_f2_q   <= dv_side.found_m;
      out_sat_q  <= sat;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.poly_value     = out_poly_q;
  assign rsp_o.root_plus      = out_rp_q;
  assign rsp_o.root_minus     = out_rm_q;
  assign rsp_o.first_found    = out_f1_q;
  assign rsp_o.second_found   = out_f2_q;
  assign rsp_o.root_saturated = out_sat_q;

  // a second root never comes without a first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (!rsp_o.second_found || rsp_o.first_found))
    else $error("second root without first");

  // no root found means zeroed roots and no saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.first_found) |->
      (rsp_o.root_plus == '0 && rsp_o.root_minus == '0 && !rsp_o.root_saturated))
    else $error("root fields set without a found root");

  // a held result stalls the request side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while result held");

endmodule

`default_nettype wire

FILE: tb/tb_quadratic_root_solver.sv
// testbench of the quadratic root solver: directed and random requests checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

module tb_quadratic_root_solver;
  import qrs_pkg::*;

  // expected result of one request
  typedef struct packed {
    logic signed [PolyW-1:0] poly;
    logic signed [RootW-1:0] rp;
    logic signed [RootW-1:0] rm;
    logic                    f1;
    logic                    f2;
    logic                    sat;
  } solution_t;

  localparam int Latency = 70;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qrs_in_if  req_if ();
  qrs_out_if rsp_if ();

  quadratic_root_solver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  solution_t solution_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_two = 0;
  int n_sat = 0;
  int n_linear = 0;
  bit sink_stall_on = 1'b1;

  // floored square root of a 64-bit value, bit by bit
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // clip to q16.16, raising the saturation flag
  function automatic logic signed [RootW-1:0] clip_root(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return RootMax;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return RootMin;
    end
    return v[RootW-1:0];
  endfunction

  // value at x and real roots of a*x*x + b*x + c, all raw integers
  function automatic solution_t solve_quadratic(logic signed [15:0] ca, logic signed [15:0] cb,
                                                logic signed [15:0] cc, logic signed [15:0] px);
    solution_t r;
    longint a, b, c, x, d, nb, s;
    logic sat;
    a = ca; b = cb; c = cc; x = px;
    sat = 1'b0;
    r = '0;
    r.poly = PolyW'(a * x * x + b * x * 256 + c * 65536);
    if (a == 0) begin
      // linear fallback, -c/b when b is nonzero
      if (b != 0) begin
        r.rp = clip_root((-c * 65536) / b, sat);
        r.f1 = 1'b1;
      end
    end else begin
      d  = b * b - 4 * a * c;
      nb = -b * 32768;
      if (d > 0) begin
        s    = floor_sqrt(d * (64'd1 << 30));
        r.rp = clip_root((nb + s) / a, sat);
        r.rm = clip_root((nb - s) / a, sat);
        r.f1 = 1'b1;
        r.f2 = 1'b1;
      end else if (d == 0) begin
        r.rp = clip_root(nb / a, sat);
        r.f1 = 1'b1;
      end
    end
    r.sat = sat;
    return r;
  endfunction

  // drive one request after a random gap and wait for it to be taken
  task automatic send_request(logic signed [15:0] ca, logic signed [15:0] cb,
                              logic signed [15:0] cc, logic signed [15:0] px);
    solution_t e;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.coef_a  <= ca;
    req_if.coef_b  <= cb;
    req_if.coef_c  <= cc;
    req_if.point_x <= px;
    do @(posedge clk_i); while (!req_if.ready);
    e = solve_quadratic(ca, cb, cc, px);
    solution_q.push_back(e);
    n_sent++;
    if (e.f2) n_two++;
    if (e.sat) n_sat++;
    if (ca == 0) n_linear++;
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_drained();
    if (req_if.valid) req_if.valid <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
  endtask

  // result checker, samples at the rising edge
  always @(posedge clk_i) begin
    solution_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (solution_q.size() == 0) begin
        $display("%0t: result with none expected: poly %0d", $time, rsp_if.poly_value);
        errors++;
      end else begin
        e = solution_q.pop_front();
        n_checked++;
        if (rsp_if.poly_value !== e.poly) begin
          $display("%0t: poly_value exp %0d got %0d", $time, e.poly, rsp_if.poly_value);
          errors++;
        end
        if (rsp_if.root_plus !== e.rp) begin
          $display("%0t: root_plus exp %0d got %0d", $time, e.rp, rsp_if.root_plus);
          errors++;
        end
        if (rsp_if.root_minus !== e.rm) begin
          $display("%0t: root_minus exp %0d got %0d", $time, e.rm, rsp_if.root_minus);
          errors++;
        end
        if (rsp_if.first_found !== e.f1) begin
          $display("%0t: first_found exp %0b got %0b", $time, e.f1, rsp_if.first_found);
          errors++;
        end
        if (rsp_if.second_found !== e.f2) begin
          $display("%0t: second_found exp %0b got %0b", $time, e.f2, rsp_if.second_found);
          errors++;
        end
        if (rsp_if.root_saturated !== e.sat) begin
          $display("%0t: root_saturated exp %0b got %0b", $time, e.sat,
                   rsp_if.root_saturated);
          errors++;
        end
      end
    end
  end

  // sink side: a random stall before each result, or none at all
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = sink_stall_on ? $urandom_range(0, 16) : 0;
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // edges of every field plus each root case
  task automatic test_directed();
    send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_request(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    send_request(-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000);
    send_request(16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff);
    send_request(0, 0, 0, 0);                  // nothing at all
    send_request(0, 0, 16'sh0100, 16'sh0100);  // linear with b zero: no root
    send_request(0, 16'sh0200, 16'sh0100, 0);  // linear root
    send_request(0, 16'sh0001, 16'sh7fff, 0);  // linear root just inside the low limit
    send_request(0, -16'sh0001, 16'sh7fff, 0); // linear root just inside the high limit
    send_request(16'sh0100, -16'sh0300, 16'sh0200, 16'sh0100); // two roots
    send_request(16'sh0100, 16'sh0200, 16'sh0100, 0);  // double root
    send_request(16'sh0100, 0, 16'sh0100, 0);          // no real root
    send_request(16'sh0001, 16'sh7fff, 0, 0);          // two roots, one near the low limit
    send_request(-16'sh0001, -16'sh8000, 16'sh0001, 0);
    send_request(16'sh0001, 16'sh0002, 16'sh0001, 16'sh0001); // tiny double root
    send_request(-16'sh0100, 0, 16'sh0400, -16'sh0200);
    send_request(16'sh0001, -16'sh8000, 16'sh7fff, 16'sh7fff);
  endtask

  // random coefficients, leaning on small values and the interesting cases
  task automatic test_random(int count);
    logic signed [15:0] ca, cb, cc, px, r;
    for (int i = 0; i < count; i++) begin
      ca = 16'($urandom); cb = 16'($urandom); cc = 16'($urandom); px = 16'($urandom);
      case ($urandom_range(0, 5))
        0: ca = 0;
        1: begin
          // perfect square: a*(x-r)^2 gives a zero discriminant
          ca = 16'($urandom_range(1, 15)); r = $signed(5'($urandom));
          cb = 16'(-2 * ca * r); cc = 16'(ca * r * r);
        end
        2: begin
          ca = $signed(8'($urandom)); cb = $signed(10'($urandom));
          cc = $signed(8'($urandom));
        end
        3: ca = $signed(2'($urandom));
        default: ;
      endcase
      send_request(ca, cb, cc, px);
    end
  endtask

  // back to back with the sink never stalling, then a full drain
  task automatic test_streaming();
    sink_stall_on = 1'b0;
    wait_drained();
    @(posedge clk_i);
    for (int i = 0; i < 200; i++) begin
      req_if.valid   <= 1'b1;
      req_if.coef_a  <= 16'($urandom);
      req_if.coef_b  <= 16'($urandom);
      req_if.coef_c  <= 16'($urandom);
      req_if.point_x <= 16'($urandom);
      do @(posedge clk_i); while (!req_if.ready);
      solution_q.push_back(solve_quadratic(req_if.coef_a, req_if.coef_b,
                                           req_if.coef_c, req_if.point_x));
      n_sent++;
    end
    wait_drained();
    sink_stall_on = 1'b1;
  endtask

  initial begin
    req_if.valid   = 1'b0;
    req_if.coef_a  = '0;
    req_if.coef_b  = '0;
    req_if.coef_c  = '0;
    req_if.point_x = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(700);
    wait_drained(); // sender holds off until the pipeline is empty
    test_streaming();
    test_random(700);

    wait_drained();
    repeat (Latency + 20) @(posedge clk_i);
    $display("covered %0d requests, %0d checked: %0d with two roots, %0d linear, %0d clipped",
             n_sent, n_checked, n_two, n_linear, n_sat);
    if (errors == 0 && solution_q.size() == 0) begin
      $display("tb_quadratic_root_solver: done, clean");
    end else begin
      $display("tb_quadratic_root_solver: done, errors");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", solution_q.size());
    $display("tb_quadratic_root_solver: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
